// ===== src/gtcs_pkg.sv =====
// package: shared types, constants and the crc byte update for the glyph table block
`timescale 1ns / 1ps
package gtcs_pkg;

  localparam int unsigned DefMaxGlyphs  = 1024;
  localparam int unsigned DefRecordBytes = 16;

  localparam logic [31:0] CrcPoly = 32'hedb88320;
  localparam logic [31:0] CrcInit = 32'hffffffff;
  localparam logic [15:0] SurrLo  = 16'hd800;
  localparam logic [15:0] SurrHi  = 16'hdfff;
  localparam logic [3:0]  PadMask = 4'hf;

  // configuration register indexes
  localparam logic [1:0] CFG_EXP_CRC   = 2'd0;
  localparam logic [1:0] CFG_EXP_COUNT = 2'd1;
  localparam logic [1:0] CFG_MAX_ADV   = 2'd2;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_COUNT    = 4'd1;
  localparam logic [3:0] ST_CRC      = 4'd2;
  localparam logic [3:0] ST_ORDER    = 4'd3;
  localparam logic [3:0] ST_SURR     = 4'd4;
  localparam logic [3:0] ST_ADVANCE  = 4'd5;
  localparam logic [3:0] ST_PADDING  = 4'd6;
  localparam logic [3:0] ST_OVERFLOW = 4'd7;
  localparam logic [3:0] ST_INVALID  = 4'd8;

  // result kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // one classified transaction waiting in the queue
  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] key;
  } entry_t;

  // reflected crc-32 over one byte, eight narrow steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== src/gtcs_if.sv =====
// interfaces: input and result channels with valid/ready handshake
`timescale 1ns / 1ps
interface gtcs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        last;
  logic [15:0] key;
  modport source (output valid, cmd, data_byte, last, key, input ready);
  modport sink (input valid, cmd, data_byte, last, key, output ready);
endinterface

interface gtcs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  status;
  logic        found;
  logic [9:0]  index;
  logic [15:0] codepoint;
  logic [7:0]  advance;
  modport source (output valid, kind, status, found, index, codepoint, advance, input ready);
  modport sink (input valid, kind, status, found, index, codepoint, advance, output ready);
endinterface

// ===== src/gtcs_front.sv =====
// front end: accepts transactions, classifies them and queues them for the back end
`timescale 1ns / 1ps
module gtcs_front (
  input  logic            clk,
  input  logic            rst,
  gtcs_in_if.sink         req,
  output logic            q_valid,
  output gtcs_pkg::entry_t q_entry,
  input  logic            q_pop
);
  import gtcs_pkg::*;

  entry_t     slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  entry_t     ent_in;

  assign req.ready = (cnt != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (cnt != 2'd0);
  assign q_entry   = slots[rp];

  // classify the incoming transaction
  always_comb begin
    ent_in.op        = req.cmd ? OP_LOOKUP : OP_LOAD;
    ent_in.data_byte = req.data_byte;
    ent_in.last      = req.last;
    ent_in.key       = req.key;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= ent_in;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ===== src/gtcs_back.sv =====
// back end: load checking, table store, binary search and result register
`timescale 1ns / 1ps
module gtcs_back #(
  parameter int unsigned MAX_GLYPHS = gtcs_pkg::DefMaxGlyphs,
  parameter int unsigned REC_LEN    = gtcs_pkg::DefRecordBytes
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             q_valid,
  input  gtcs_pkg::entry_t q_entry,
  output logic             q_pop,
  gtcs_out_if.source       rsp
);
  import gtcs_pkg::*;

  localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int CW = $clog2(MAX_GLYPHS + 2);
  localparam int PW = $clog2(REC_LEN);
  localparam logic [CW-1:0] MaxG    = CW'(MAX_GLYPHS);
  localparam logic [PW-1:0] LastPos = PW'(REC_LEN - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration
  logic [31:0] exp_crc;
  logic [10:0] exp_count;
  logic [7:0]  max_adv;

  // load state
  logic [31:0]   crc;
  logic [PW-1:0] pos;
  logic [CW-1:0] rcount;
  logic [15:0]   prev_code;
  logic [15:0]   cur_code;
  logic [7:0]    cur_adv;
  logic [3:0]    first_err;
  logic          table_valid;
  logic [CW-1:0] table_count;

  // store and search
  logic [23:0]   mem [MAX_GLYPHS];
  logic [23:0]   rd_data;
  logic [CW-1:0] lo, hi, mid;
  logic [15:0]   key;

  // pending result
  logic [3:0]  res_status;
  logic        res_found;
  logic [9:0]  res_index;
  logic [15:0] res_code;
  logic [7:0]  res_adv;

  logic        out_free;
  logic        do_load, do_inval, do_start, do_read, mem_we;
  logic [31:0] crc_n;
  logic [15:0] code_n;
  logic [7:0]  adv_n;
  logic        end_rec;
  logic [3:0]  err, ferr_n, load_status;
  logic [CW-1:0] rcount_n;
  logic [PW-1:0] pos_n;
  logic [CW-1:0] mid_calc;

  assign out_free = !rsp.valid || rsp.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_crc   <= '0;
      exp_count <= '0;
      max_adv   <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXP_CRC:   exp_crc   <= cfg_data;
        CFG_EXP_COUNT: exp_count <= cfg_data[10:0];
        CFG_MAX_ADV:   max_adv   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // dispatch decisions
  always_comb begin
    do_load  = (state == S_IDLE) && q_valid && (q_entry.op == OP_LOAD)
               && (!q_entry.last || out_free);
    do_inval = (state == S_IDLE) && q_valid && (q_entry.op == OP_LOOKUP)
               && !table_valid && out_free;
    do_start = (state == S_IDLE) && q_valid && (q_entry.op == OP_LOOKUP) && table_valid;
    q_pop    = do_load || do_inval || do_start;
  end

  // per-byte load checks
  always_comb begin
    crc_n   = crc_byte(crc, q_entry.data_byte);
    code_n  = cur_code;
    adv_n   = cur_adv;
    if (pos == PW'(0)) code_n = {8'd0, q_entry.data_byte};
    else if (pos == PW'(1)) code_n = {q_entry.data_byte, cur_code[7:0]};
    else if (pos == PW'(2)) adv_n = q_entry.data_byte;
    end_rec = (pos == LastPos);
    if (rcount != '0 && code_n <= prev_code) err = ST_ORDER;
    else if (code_n >= SurrLo && code_n <= SurrHi) err = ST_SURR;
    else if (adv_n == 8'd0 || adv_n > max_adv) err = ST_ADVANCE;
    else if ((q_entry.data_byte[3:0] & PadMask) != 4'd0) err = ST_PADDING;
    else err = ST_OK;
    ferr_n   = (end_rec && first_err == ST_OK) ? err : first_err;
    rcount_n = (end_rec && rcount <= MaxG) ? rcount + CW'(1) : rcount;
    pos_n    = end_rec ? '0 : pos + PW'(1);
    mem_we   = do_load && end_rec && (rcount < MaxG);
    if (exp_count == 11'd0 || pos_n != '0 || 32'(rcount_n) != 32'(exp_count))
      load_status = ST_COUNT;
    else if (rcount_n > MaxG) load_status = ST_OVERFLOW;
    else if (~crc_n != exp_crc) load_status = ST_CRC;
    else load_status = ferr_n;
  end

  // search midpoint
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign do_read  = (state == S_RD) && (lo < hi);

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[rcount[AW-1:0]] <= {adv_n, code_n};
    if (do_read) rd_data <= mem[mid_calc[AW-1:0]];
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (do_start) state_next = S_RD;
      S_RD:   state_next = (lo < hi) ? S_CMP : S_DONE;
      S_CMP:  state_next = (rd_data[15:0] == key) ? S_DONE : S_RD;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      crc         <= CrcInit;
      pos         <= '0;
      rcount      <= '0;
      prev_code   <= '0;
      cur_code    <= '0;
      cur_adv     <= '0;
      first_err   <= ST_OK;
      table_valid <= 1'b0;
      table_count <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      // result valid: raised by a new result, dropped once taken
      if ((do_load && q_entry.last) || do_inval || (state == S_DONE && out_free))
        rsp.valid <= 1'b1;
      else if (rsp.ready)
        rsp.valid <= 1'b0;
      if (do_load) begin
        table_valid <= q_entry.last && (load_status == ST_OK);
        if (q_entry.last) begin
          crc       <= CrcInit;
          pos       <= '0;
          rcount    <= '0;
          prev_code <= '0;
          cur_code  <= '0;
          cur_adv   <= '0;
          first_err <= ST_OK;
          if (load_status == ST_OK) table_count <= rcount_n;
        end else begin
          crc       <= crc_n;
          pos       <= pos_n;
          rcount    <= rcount_n;
          cur_code  <= code_n;
          cur_adv   <= adv_n;
          first_err <= ferr_n;
          if (end_rec) prev_code <= code_n;
        end
      end
    end
  end

  // search bounds and pending result
  always_ff @(posedge clk) begin
    if (do_start) begin
      lo  <= '0;
      hi  <= (table_count > MaxG) ? MaxG : table_count;
      key <= q_entry.key;
      res_status <= ST_OK;
      res_found  <= 1'b0;
      res_index  <= '0;
      res_code   <= '0;
      res_adv    <= '0;
    end
    if (do_read) mid <= mid_calc;
    if (state == S_CMP) begin
      if (rd_data[15:0] < key) lo <= mid + CW'(1);
      else if (rd_data[15:0] > key) hi <= mid;
      else begin
        res_found <= 1'b1;
        res_index <= 10'(mid);
        res_code  <= rd_data[15:0];
        res_adv   <= rd_data[23:16];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (do_load && q_entry.last) begin
      rsp.kind      <= KIND_LOAD;
      rsp.status    <= load_status;
      rsp.found     <= 1'b0;
      rsp.index     <= '0;
      rsp.codepoint <= '0;
      rsp.advance   <= '0;
    end else if (do_inval) begin
      rsp.kind      <= KIND_LOOKUP;
      rsp.status    <= ST_INVALID;
      rsp.found     <= 1'b0;
      rsp.index     <= '0;
      rsp.codepoint <= '0;
      rsp.advance   <= '0;
    end else if (state == S_DONE && out_free) begin
      rsp.kind      <= KIND_LOOKUP;
      rsp.status    <= res_status;
      rsp.found     <= res_found;
      rsp.index     <= res_index;
      rsp.codepoint <= res_code;
      rsp.advance   <= res_adv;
    end
  end
endmodule

// ===== src/glyph_table_check_and_search.sv =====
// top level: glyph table loader, checker and binary searcher
//
// Transactions arrive on req (valid/ready). cmd 0 loads one payload byte;
// the byte marked last ends the load and gives one status result on rsp.
// cmd 1 looks up a codepoint and always gives one result on rsp.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
// index 0 expected crc, 1 expected glyph count, 2 max advance.
// A two-entry queue sits between the accepting front end and the back end.
// In the back end a lookup runs each binary search step as a memory read
// (S_RD), then a compare (S_CMP), and takes no new transaction from the
// queue until the search is done and its result is passed on.
// Results sit in an output register; while rsp is stalled the back end
// holds its next result and the queue still takes up to two transactions.
// Reset is synchronous: table invalid, load counters and crc cleared, no
// result pending; the table memory is not cleared.
`timescale 1ns / 1ps
module glyph_table_check_and_search #(
  parameter int unsigned MAX_GLYPHS = gtcs_pkg::DefMaxGlyphs,
  parameter int unsigned REC_LEN    = gtcs_pkg::DefRecordBytes
) (
  input  logic        clk,
  input  logic        rst,
  gtcs_in_if.sink     req,
  gtcs_out_if.source  rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import gtcs_pkg::*;

  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;

  // front end with queue
  gtcs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  // back end
  gtcs_back #(
    .MAX_GLYPHS (MAX_GLYPHS),
    .REC_LEN    (REC_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .rsp       (rsp)
  );

  // checks
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_hit_is_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.kind == KIND_LOOKUP && rsp.status == ST_OK)
    else $error("hit with bad kind or status");
  a_load_no_hit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.kind == KIND_LOAD |-> !rsp.found && rsp.advance == 8'd0)
    else $error("load status carries lookup data");
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp.valid) else $error("result after reset");
endmodule
